// File: rtl/sbl_pkg.sv
// Shared types and constants for the serial bus byte listener.
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

	// Payload field widths
	localparam int ELAPSED_W = 8;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 16;
	localparam int BITCNT_W  = 4;

	// APB port geometry
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_EOI_TIMEOUT = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] EOI_TIMEOUT_RST = 16'd160;
	localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 16'd200;

	// Bits per byte on the bus
	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	// Handshake phases
	typedef enum logic [5:0] {
		PH_IDLE           = 6'b000001,
		PH_READY_TO_SEND  = 6'b000010,
		PH_READY_FOR_DATA = 6'b000100,
		PH_EOI_ACK        = 6'b001000,
		PH_BITS           = 6'b010000,
		PH_FRAME_ACK      = 6'b100000
	} phase_t;

	// Configuration register contents
	typedef struct packed {
		logic [CFG_W-1:0] eoi_timeout;
		logic [CFG_W-1:0] ack_timeout;
	} cfg_t;

	// One bus tick
	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_time;
		logic                 clock_line;
		logic                 data_line_others;
	} tick_t;

	// One result
	typedef struct packed {
		logic              data_drive;
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_value;
		logic              last_byte;
	} result_t;

endpackage : sbl_pkg

`default_nettype wire

// File: rtl/sbl_if.sv
// Valid/ready channel interfaces for bus ticks and listener results.
`timescale 1ns / 1ps
`default_nettype none

interface sbl_tick_if;
	logic                           valid;
	logic                           ready;
	logic [sbl_pkg::ELAPSED_W-1:0]  elapsed_time;
	logic                           clock_line;
	logic                           data_line_others;

	modport source (output valid, elapsed_time, clock_line, data_line_others, input ready);
	modport sink   (input valid, elapsed_time, clock_line, data_line_others, output ready);
endinterface : sbl_tick_if

interface sbl_result_if;
	logic                        valid;
	logic                        ready;
	logic                        data_drive;
	logic                        byte_valid;
	logic [sbl_pkg::BYTE_W-1:0]  byte_value;
	logic                        last_byte;

	modport source (output valid, data_drive, byte_valid, byte_value, last_byte, input ready);
	modport sink   (input valid, data_drive, byte_valid, byte_value, last_byte, output ready);
endinterface : sbl_result_if

`default_nettype wire

// File: rtl/sbl_apb_regs.sv
// APB register file holding the EOI and acknowledge timeouts.
`timescale 1ns / 1ps
`default_nettype none

module sbl_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sbl_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [sbl_pkg::PDATA_W-1:0]   pwdata,
	output logic      [sbl_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output sbl_pkg::cfg_t                      cfg
);
	import sbl_pkg::*;

	logic [CFG_W-1:0] eoi_timeout_q;
	logic [CFG_W-1:0] ack_timeout_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eoi_timeout_q <= EOI_TIMEOUT_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			if (reg_sel == REG_EOI_TIMEOUT) begin
				eoi_timeout_q <= pwdata[CFG_W-1:0];
			end else begin
				ack_timeout_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Read mux
	always_comb begin
		if (reg_sel == REG_EOI_TIMEOUT) begin
			prdata = PDATA_W'(eoi_timeout_q);
		end else begin
			prdata = PDATA_W'(ack_timeout_q);
		end
	end

	assign cfg.eoi_timeout = eoi_timeout_q;
	assign cfg.ack_timeout = ack_timeout_q;

endmodule : sbl_apb_regs

`default_nettype wire

// File: rtl/sbl_handshake.sv
// Listener handshake state machine: timer, bit gathering and data drive.
`timescale 1ns / 1ps
`default_nettype none

module sbl_handshake #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire sbl_pkg::tick_t    tick,
	input  wire sbl_pkg::cfg_t     cfg,
	output sbl_pkg::result_t       result
);
	import sbl_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	// Handshake state
	phase_t                  phase_q;
	logic [TIMER_WIDTH-1:0]  timer_q;
	logic [BITCNT_W-1:0]     bit_count_q;
	logic [BYTE_W-1:0]       shift_q;
	logic                    prev_clock_q;
	logic                    eoi_flag_q;
	logic                    own_data_q;

	// Next state
	phase_t                  phase_d;
	logic [TIMER_WIDTH-1:0]  timer_d;
	logic [BITCNT_W-1:0]     bit_count_d;
	logic [BYTE_W-1:0]       shift_d;
	logic                    prev_clock_d;
	logic                    eoi_flag_d;
	logic                    own_data_d;
	logic                    byte_valid;
	logic [BYTE_W-1:0]       byte_value;

	logic [TIMER_WIDTH:0]    timer_sum;
	logic [TIMER_WIDTH-1:0]  timer_sat;
	logic                    eoi_expired;
	logic                    ack_expired;
	logic [BITCNT_W-1:0]     bit_count_inc;

	// Saturating timer and timeout compares
	assign timer_sum   = {1'b0, timer_q} + (TIMER_WIDTH+1)'(tick.elapsed_time);
	assign timer_sat   = timer_sum[TIMER_WIDTH] ? '1 : timer_sum[TIMER_WIDTH-1:0];
	assign eoi_expired = CMP_W'(timer_sat) > CMP_W'(cfg.eoi_timeout);
	assign ack_expired = CMP_W'(timer_sat) > CMP_W'(cfg.ack_timeout);
	assign bit_count_inc = bit_count_q + BITCNT_W'(1);

	// Phase transitions for one tick
	always_comb begin
		phase_d      = phase_q;
		timer_d      = timer_sat;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		prev_clock_d = prev_clock_q;
		eoi_flag_d   = eoi_flag_q;
		own_data_d   = own_data_q;
		byte_valid   = 1'b0;
		byte_value   = '0;

		case (phase_q)
			PH_READY_TO_SEND: begin
				if (!tick.clock_line) begin
					own_data_d = 1'b0;
					phase_d    = PH_READY_FOR_DATA;
					timer_d    = '0;
					eoi_flag_d = 1'b0;
				end
			end
			PH_READY_FOR_DATA: begin
				if (tick.clock_line) begin
					phase_d      = PH_BITS;
					bit_count_d  = '0;
					shift_d      = '0;
					prev_clock_d = 1'b1;
				end else if (!eoi_flag_q && eoi_expired) begin
					eoi_flag_d = 1'b1;
					own_data_d = 1'b1;
					phase_d    = PH_EOI_ACK;
					timer_d    = '0;
				end
			end
			PH_EOI_ACK: begin
				if (ack_expired) begin
					own_data_d = 1'b0;
					phase_d    = PH_READY_FOR_DATA;
					timer_d    = '0;
				end
			end
			PH_BITS: begin
				// Sample on clock release; released data reads as one
				if (prev_clock_q && !tick.clock_line) begin
					bit_count_d = bit_count_inc;
					shift_d     = {~(own_data_q | tick.data_line_others), shift_q[BYTE_W-1:1]};
					if (bit_count_inc == BITS_PER_BYTE) begin
						bit_count_d = '0;
						phase_d     = PH_FRAME_ACK;
						timer_d     = '0;
					end
				end
				prev_clock_d = tick.clock_line;
			end
			PH_FRAME_ACK: begin
				if (tick.clock_line) begin
					own_data_d = 1'b1;
					if (ack_expired) begin
						timer_d    = '0;
						phase_d    = PH_IDLE;
						byte_valid = 1'b1;
						byte_value = shift_q;
					end
				end
			end
			default: begin
				// Idle: talker asserts clock, answer with data held
				if (tick.clock_line) begin
					own_data_d = 1'b1;
					phase_d    = PH_READY_TO_SEND;
				end
			end
		endcase
	end

	// State registers, advanced once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			bit_count_q  <= '0;
			shift_q      <= '0;
			prev_clock_q <= 1'b1;
			eoi_flag_q   <= 1'b0;
			own_data_q   <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			timer_q      <= timer_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			prev_clock_q <= prev_clock_d;
			eoi_flag_q   <= eoi_flag_d;
			own_data_q   <= own_data_d;
		end
	end

	assign result.data_drive = own_data_d;
	assign result.byte_valid = byte_valid;
	assign result.byte_value = byte_value;
	assign result.last_byte  = eoi_flag_d;

	// Checks
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("handshake phase lost its one-hot code");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q < BITS_PER_BYTE)
		else $error("bit count reached a full byte without wrapping");

	a_byte_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && byte_valid |=> phase_q == PH_IDLE && own_data_q && timer_q == '0)
		else $error("completed byte did not return to idle with data held");

	a_eoi_ack_drives: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EOI_ACK |-> own_data_q && eoi_flag_q)
		else $error("EOI acknowledge without own data drive");

	a_rfd_entry: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_READY_TO_SEND && !tick.clock_line
		|=> phase_q == PH_READY_FOR_DATA && !eoi_flag_q && !own_data_q)
		else $error("ready-for-data entered with stale EOI or data drive");

endmodule : sbl_handshake

`default_nettype wire

// File: rtl/serial_bus_byte_listener_core.sv
// Serial bus byte listener: top level with tick pipeline and APB registers.
//
// Usage:
//   tick   : one bus time tick per transfer (elapsed_time, clock_line,
//            data_line_others). The block listens on a wired-OR clock/data
//            bus and drives only its own data line.
//   result : one transfer per tick: data_drive, byte_valid, byte_value,
//            last_byte (EOI seen for the current byte).
//   APB    : eoi_timeout at 0x0, ack_timeout at 0x4; write only while idle.
// Timing:
//   A tick is captured in the input stage, processed in one pass through
//   the handshake logic and lands in the result register, from which its
//   result is offered. One tick per cycle is sustained while result.ready
//   stays high; the state update of each tick is a loop through the
//   handshake state registers.
// Reset: arst_n clears both stages and returns the handshake to idle with
//   the timeouts at 160 and 200.
// Stall: when result.ready is low the result register holds; the input
//   stage takes one more tick only if it is empty, then tick.ready drops
//   until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module serial_bus_byte_listener_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sbl_tick_if.sink                           tick,
	sbl_result_if.source                       result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sbl_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [sbl_pkg::PDATA_W-1:0]   pwdata,
	output logic      [sbl_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import sbl_pkg::*;

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    step;

	// Configuration registers
	sbl_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: result slot free or being drained
	assign advance    = !valid_s2 || result.ready;
	assign step       = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			tick_s1.elapsed_time     <= tick.elapsed_time;
			tick_s1.clock_line       <= tick.clock_line;
			tick_s1.data_line_others <= tick.data_line_others;
		end
	end

	// Handshake logic
	sbl_handshake #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_handshake (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid      = valid_s2;
	assign result.data_drive = res_s2.data_drive;
	assign result.byte_valid = res_s2.byte_valid;
	assign result.byte_value = res_s2.byte_value;
	assign result.last_byte  = res_s2.last_byte;

endmodule : serial_bus_byte_listener_core

`default_nettype wire
